### hdl/svm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_pkg
// opcodes, status codes, register indexes and memory control type shared by
// the stack machine executor files
// ----------------------------------------------------------------------------
package svm_pkg;

   // opcodes
   localparam logic [2:0] OP_PUSH = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_POP  = 3'd2;
   localparam logic [2:0] OP_PEEK = 3'd3;
   localparam logic [2:0] OP_SET  = 3'd4;
   localparam logic [2:0] OP_HALT = 3'd5;

   // status codes
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_HALTED = 3'd1;
   localparam logic [2:0] ST_OVER   = 3'd2;
   localparam logic [2:0] ST_UNDER  = 3'd3;
   localparam logic [2:0] ST_BADREG = 3'd4;
   localparam logic [2:0] ST_BADOP  = 3'd5;

   // register file indexes
   localparam logic [3:0] IDX_RP = 4'd6;
   localparam logic [3:0] IDX_IP = 4'd7;
   localparam logic [3:0] IDX_SP = 4'd8;
   localparam int         REG_COUNT = 9;

   // stack memory strobes
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_ctl_type;

endpackage

### hdl/svm_stack_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_stack_ram
// stack word memory: one write port, two read ports with registered data
// ----------------------------------------------------------------------------
module svm_stack_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  logic                       clock,
   input  svm_pkg::ram_ctl_type       ctl,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
   output logic [WIDTH-1:0]           rd_data_a,
   output logic [WIDTH-1:0]           rd_data_b,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data
);

   logic [WIDTH-1:0] stack_mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         stack_mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read strobe
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_a_ff <= stack_mem_ff[rd_addr_a];
         rd_data_b_ff <= stack_mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

### hdl/stack_vm_executor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_vm_executor_core
// executes one stack machine instruction per transfer and returns one result
// ----------------------------------------------------------------------------
// result path: the instruction is held in the execute register, its result in
//   the result register once free; a held result delays it until it is taken
// input: takes a new instruction only after the one in execute moves on; it stays
//   closed while an instruction sits in execute on its stack memory read
// reset: synchronous, active high; sp goes to -1, rp, ip and halted to 0,
//   stack words are not cleared (no clearing pass, no valid bits)
// ----------------------------------------------------------------------------
module stack_vm_executor_core #(
   parameter int STACK_DEPTH = 256,
   parameter int DATA_WIDTH  = 32
) (
   input  logic          clock,
   input  logic          reset,
   // instruction channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,   // operand_first[31:0], operand_second[63:32]
   input  logic [2:0]    req_tuser,   // opcode[2:0]
   // result channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata    // status[2:0], reg_written[3], dest_index[7:4],
                                      // written_value[39:8], stack_top_index[71:40],
                                      // next_instr_pointer[103:72]
);

   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int AW1 = AW + 1;
   // compare width: holds sp sign-extended and the stack depth bounds
   localparam int CW  = ((DATA_WIDTH > AW1) ? DATA_WIDTH : AW1) + 1;

   localparam logic signed [CW-1:0] SP_EMPTY = '1;
   localparam logic signed [CW-1:0] ADD_MIN  = CW'(1);
   localparam logic signed [CW-1:0] TOP_MAX  = CW'(STACK_DEPTH - 1);
   localparam logic signed [CW-1:0] PUSH_MAX = CW'(STACK_DEPTH - 2);

   // architectural state (the general words A..F have no read path,
   // so only rp, ip and sp are held here)
   logic [DATA_WIDTH-1:0] sp_ff, sp_in;
   logic [DATA_WIDTH-1:0] ip_ff, ip_in;
   logic [DATA_WIDTH-1:0] rp_ff, rp_in;
   logic                  halted_ff, halted_in;

   // execute stage
   logic                  ex_valid_ff;
   logic [2:0]            ex_op_ff;
   logic [31:0]           ex_a_ff;
   logic [31:0]           ex_b_ff;

   // result register
   logic                  rsp_valid_ff;
   logic [103:0]          rsp_data_ff, rsp_data_in;

   logic                  req_xfer;
   logic                  ex_fire;

   // stack memory
   svm_pkg::ram_ctl_type  ram_ctl;
   logic [DATA_WIDTH-1:0] rd_top;
   logic [DATA_WIDTH-1:0] rd_next;
   logic [AW-1:0]         rd_addr_a;
   logic [AW-1:0]         rd_addr_b;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  push_ok;

   // sp in the compare width
   logic signed [CW-1:0]  sp_s;
   logic signed [CW-1:0]  sp_p1;
   logic signed [CW-1:0]  sp_m1;

   // operands fitted to the word width
   logic [DATA_WIDTH+31:0] a_ext;
   logic [DATA_WIDTH+31:0] b_ext;
   logic [DATA_WIDTH-1:0]  a_word;
   logic [DATA_WIDTH-1:0]  b_word;

   // execute results
   logic [2:0]            ex_status;
   logic                  ex_wrote;
   logic [3:0]            ex_dest;
   logic [DATA_WIDTH-1:0] ex_value;

   // 32-bit views of the result words
   logic [DATA_WIDTH+31:0] value_ext;
   logic [DATA_WIDTH+31:0] sp_ext;
   logic [DATA_WIDTH+31:0] ip_ext;
   logic [31:0]            value_out;

   // one instruction in execute at a time; the result register parts the sides
   assign req_tready = !ex_valid_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign ex_fire    = ex_valid_ff && (!rsp_valid_ff || rsp_tready);

   assign sp_s  = CW'(signed'(sp_ff));
   assign sp_p1 = sp_s + CW'(1);
   assign sp_m1 = sp_s - CW'(1);

   // top two words are read at the instruction transfer, state is current then
   assign rd_addr_a = sp_s[AW-1:0];
   assign rd_addr_b = sp_m1[AW-1:0];
   assign wr_addr   = sp_p1[AW-1:0];
   assign wr_data   = a_word;

   assign ram_ctl.rd_en = req_xfer;
   assign ram_ctl.wr_en = ex_fire && push_ok;

   svm_stack_ram #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (DATA_WIDTH)
   ) u_stack (
      .clock     (clock),
      .ctl       (ram_ctl),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_top),
      .rd_data_b (rd_next),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   // sign-extend the 32-bit operands, then cut to the word width
   assign a_ext  = {{DATA_WIDTH{ex_a_ff[31]}}, ex_a_ff};
   assign b_ext  = {{DATA_WIDTH{ex_b_ff[31]}}, ex_b_ff};
   assign a_word = a_ext[DATA_WIDTH-1:0];
   assign b_word = b_ext[DATA_WIDTH-1:0];

   // execute: status checks, then the destination write, then the ip step
   always_comb begin
      logic                  rp_ok;
      logic                  set_ok;
      logic [DATA_WIDTH-1:0] sp_base;
      logic [DATA_WIDTH-1:0] ip_base;

      rp_ok     = !rp_ff[DATA_WIDTH-1] && (rp_ff <= DATA_WIDTH'(svm_pkg::IDX_SP));
      set_ok    = (ex_a_ff < 32'(svm_pkg::REG_COUNT));
      sp_base   = sp_ff;
      ip_base   = ip_ff;
      ex_status = svm_pkg::ST_OK;
      ex_wrote  = 1'b0;
      ex_dest   = 4'd0;
      ex_value  = '0;
      push_ok   = 1'b0;
      halted_in = halted_ff;

      if (halted_ff) begin
         ex_status = svm_pkg::ST_HALTED;
      end else begin
         unique case (ex_op_ff)
            svm_pkg::OP_PUSH: begin
               priority if (sp_s > PUSH_MAX) begin
                  ex_status = svm_pkg::ST_OVER;
               end else if (sp_s < SP_EMPTY) begin
                  ex_status = svm_pkg::ST_UNDER;
               end else begin
                  push_ok = 1'b1;
                  sp_base = sp_ff + DATA_WIDTH'(1);
                  ip_base = ip_ff + DATA_WIDTH'(2);
               end
            end
            svm_pkg::OP_ADD, svm_pkg::OP_POP, svm_pkg::OP_PEEK: begin
               priority if (!rp_ok) begin
                  ex_status = svm_pkg::ST_BADREG;
               end else if ((ex_op_ff == svm_pkg::OP_ADD) ? (sp_s < ADD_MIN) : sp_s[CW-1]) begin
                  ex_status = svm_pkg::ST_UNDER;
               end else if (sp_s > TOP_MAX) begin
                  ex_status = svm_pkg::ST_OVER;
               end else begin
                  ex_wrote = 1'b1;
                  ex_dest  = rp_ff[3:0];
                  ip_base  = ip_ff + DATA_WIDTH'(1);
                  if (ex_op_ff == svm_pkg::OP_ADD) begin
                     ex_value = rd_top + rd_next;
                     sp_base  = sp_ff - DATA_WIDTH'(2);
                  end else begin
                     ex_value = rd_top;
                     if (ex_op_ff == svm_pkg::OP_POP) begin
                        sp_base = sp_ff - DATA_WIDTH'(1);
                     end
                  end
               end
            end
            svm_pkg::OP_SET: begin
               if (!set_ok) begin
                  ex_status = svm_pkg::ST_BADREG;
               end else begin
                  ex_wrote = 1'b1;
                  ex_dest  = ex_a_ff[3:0];
                  ex_value = b_word;
                  ip_base  = ip_ff + DATA_WIDTH'(3);
               end
            end
            svm_pkg::OP_HALT: begin
               halted_in = 1'b1;
               ip_base   = ip_ff + DATA_WIDTH'(1);
            end
            default: begin
               ex_status = svm_pkg::ST_BADOP;
            end
         endcase
      end

      // destination write lands before the final ip step
      sp_in = (ex_wrote && (ex_dest == svm_pkg::IDX_SP)) ? ex_value : sp_base;
      ip_in = (ex_wrote && (ex_dest == svm_pkg::IDX_IP)) ? ex_value + DATA_WIDTH'(1)
                                                         : ip_base;
      rp_in = (ex_wrote && (ex_dest == svm_pkg::IDX_RP)) ? ex_value : rp_ff;
   end

   // words sign-extended to 32-bit fields
   assign value_ext = {{32{ex_value[DATA_WIDTH-1]}}, ex_value};
   assign sp_ext    = {{32{sp_in[DATA_WIDTH-1]}}, sp_in};
   assign ip_ext    = {{32{ip_in[DATA_WIDTH-1]}}, ip_in};
   assign value_out = ex_wrote ? value_ext[31:0] : 32'd0;

   assign rsp_data_in = {ip_ext[31:0], sp_ext[31:0], value_out, ex_dest, ex_wrote, ex_status};

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '1;
         ip_ff        <= '0;
         rp_ff        <= '0;
         halted_ff    <= 1'b0;
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            ex_valid_ff <= 1'b1;
         end else if (ex_fire) begin
            ex_valid_ff <= 1'b0;
         end
         if (ex_fire) begin
            sp_ff        <= sp_in;
            ip_ff        <= ip_in;
            rp_ff        <= rp_in;
            halted_ff    <= halted_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ex_op_ff <= req_tuser;
         ex_a_ff  <= req_tdata[31:0];
         ex_b_ff  <= req_tdata[63:32];
      end
      if (ex_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // once halted, the machine stays halted until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted flag cleared without reset");

   // an instruction after halt writes no register
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      (ex_fire && halted_ff) |-> (ex_status == svm_pkg::ST_HALTED && !ex_wrote))
      else $error("instruction after halt had an effect");

   // a faulting instruction leaves sp and ip as they were
   a_fault_stable: assert property (@(posedge clock) disable iff (reset)
      (ex_fire && ex_status != svm_pkg::ST_OK) |=> ($stable(sp_ff) && $stable(ip_ff)))
      else $error("faulting instruction changed sp or ip");

   // a stack write only happens with sp inside the push window
   a_push_window: assert property (@(posedge clock) disable iff (reset)
      ram_ctl.wr_en |-> (sp_s >= SP_EMPTY && sp_s <= PUSH_MAX))
      else $error("stack write outside the stack range");

endmodule
